/* rtl/core/hbwd_pkg.sv */
// types, constants and helpers for the heartbeat reboot watchdog
// no dependencies; used by heartbeat_reboot_watchdog

package hbwd_pkg;

  // width of the saturating tick counters (8 to 32)
  localparam int COUNT_WIDTH = 16;
  // width used to compare a counter against a 16-bit limit
  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  localparam logic [15:0] FAN_STALE_PERIOD = 16'hFFFF;

  // watchdog state codes
  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_PULSE = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  // request kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_HBEAT   = 2'd1;
  localparam logic [1:0] KIND_CAPTURE = 2'd2;
  localparam logic [1:0] KIND_CONTROL = 2'd3;

  // control byte fields
  localparam int CTL_ACTIVE_BIT   = 7;
  localparam int CTL_OVERRIDE_BIT = 2;

  // configuration register indexes
  localparam logic [2:0] REG_INITIAL_WAIT = 3'd0;
  localparam logic [2:0] REG_HB_LIMIT     = 3'd1;
  localparam logic [2:0] REG_PULSE        = 3'd2;
  localparam logic [2:0] REG_HOLDOFF      = 3'd3;
  localparam logic [2:0] REG_FAN_STALE    = 3'd4;

  // reset values of the configuration registers
  localparam logic [15:0] RST_INITIAL_WAIT = 16'd30;
  localparam logic [15:0] RST_HB_LIMIT     = 16'd10;
  localparam logic [15:0] RST_PULSE        = 16'd2;
  localparam logic [15:0] RST_HOLDOFF      = 16'd60;
  localparam logic [15:0] RST_FAN_STALE    = 16'd16;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] capture_value;
    logic [7:0]  control_value;
  } in_item_t;

  typedef struct packed {
    logic        reboot_out;
    logic [7:0]  status;
    logic [15:0] reboot_count;
    logic [15:0] fan_period;
    logic [15:0] heartbeat_interval;
  } out_item_t;

  // saturating increment
  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : cnt_t'(v + cnt_t'(1));
  endfunction

  // counter >= 16-bit limit, both widened to a common width
  function automatic logic cnt_ge(input cnt_t c, input logic [15:0] lim);
    return CMP_W'(c) >= CMP_W'(lim);
  endfunction

  // counter as a 16-bit result field
  function automatic logic [15:0] cnt_out(input cnt_t c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    return w[15:0];
  endfunction

endpackage

/* rtl/core/heartbeat_reboot_watchdog.sv */
// heartbeat reboot watchdog top level: state update, result register and skid stage
// depends on hbwd_pkg

// Heartbeat supervisor with reboot pulse and fan tacho period capture. Every
// request (tick, heartbeat edge, tacho capture or control write) updates the
// watchdog state in the cycle it is accepted and yields exactly one result,
// which is registered before it reaches out_data. While in_stall is low a request
// can be accepted every cycle; the rate is one per clock, set by the single pass of
// compare/increment logic in front of the state registers. A two-deep output
// (result register plus skid register) keeps requests flowing while one result is
// stalled; in_stall rises only once both are full. The watchdog walks initial wait,
// wait, reboot pulse and hold-off on ticks, and a control override can force its
// state; saturating counters are compared against the configuration limits.
// Registers are written through the cfg port (always ready), by the user only while
// the block is idle (the block does not enforce it); indexes above 4 are ignored.

module heartbeat_reboot_watchdog (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hbwd_pkg::in_item_t   in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output hbwd_pkg::out_item_t  out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  // configuration registers
  logic [15:0] initial_wait_r, hb_limit_r, pulse_r, holdoff_r, fan_stale_r;

  // watchdog state
  logic [1:0]      wd_state_r, wd_state_nxt;
  logic            active_r, active_nxt;
  logic            pin_level_r, pin_level_nxt;
  hbwd_pkg::cnt_t  state_cnt_r, state_cnt_nxt;
  hbwd_pkg::cnt_t  since_hb_r, since_hb_nxt;
  hbwd_pkg::cnt_t  last_int_r, last_int_nxt;
  hbwd_pkg::cnt_t  fan_idle_r, fan_idle_nxt;
  logic [15:0]     cap_now_r, cap_now_nxt;
  logic [15:0]     cap_prev_r, cap_prev_nxt;

  // output register and skid stage
  logic                 out_vld_r, skid_vld_r;
  hbwd_pkg::out_item_t  out_r, skid_r;
  hbwd_pkg::out_item_t  res_nxt;

  logic           in_acc, out_take;
  logic [1:0]     tick_state;
  hbwd_pkg::cnt_t cnt_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_vld_r && !out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_wait_r <= hbwd_pkg::RST_INITIAL_WAIT;
      hb_limit_r     <= hbwd_pkg::RST_HB_LIMIT;
      pulse_r        <= hbwd_pkg::RST_PULSE;
      holdoff_r      <= hbwd_pkg::RST_HOLDOFF;
      fan_stale_r    <= hbwd_pkg::RST_FAN_STALE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hbwd_pkg::REG_INITIAL_WAIT: initial_wait_r <= cfg_data;
        hbwd_pkg::REG_HB_LIMIT:     hb_limit_r     <= cfg_data;
        hbwd_pkg::REG_PULSE:        pulse_r        <= cfg_data;
        hbwd_pkg::REG_HOLDOFF:      holdoff_r      <= cfg_data;
        hbwd_pkg::REG_FAN_STALE:    fan_stale_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state for the accepted request
  assign cnt_inc    = hbwd_pkg::sat_inc(state_cnt_r);
  assign tick_state = active_r ? wd_state_r : hbwd_pkg::ST_INIT;

  always_comb begin
    wd_state_nxt  = wd_state_r;
    active_nxt    = active_r;
    pin_level_nxt = pin_level_r;
    state_cnt_nxt = state_cnt_r;
    since_hb_nxt  = since_hb_r;
    last_int_nxt  = last_int_r;
    fan_idle_nxt  = fan_idle_r;
    cap_now_nxt   = cap_now_r;
    cap_prev_nxt  = cap_prev_r;

    case (in_data.kind)
      hbwd_pkg::KIND_TICK: begin
        since_hb_nxt = hbwd_pkg::sat_inc(since_hb_r);
        if (!hbwd_pkg::cnt_ge(fan_idle_r, fan_stale_r)) begin
          fan_idle_nxt = hbwd_pkg::sat_inc(fan_idle_r);
        end
        wd_state_nxt = tick_state;
        unique case (tick_state)
          hbwd_pkg::ST_INIT: begin
            state_cnt_nxt = cnt_inc;
            if (hbwd_pkg::cnt_ge(cnt_inc, initial_wait_r)) begin
              state_cnt_nxt = '0;
              wd_state_nxt  = hbwd_pkg::ST_WAIT;
            end
          end
          hbwd_pkg::ST_WAIT: begin
            // uses the already incremented heartbeat age
            if (hbwd_pkg::cnt_ge(since_hb_nxt, hb_limit_r)) begin
              wd_state_nxt = hbwd_pkg::ST_PULSE;
            end
          end
          hbwd_pkg::ST_PULSE: begin
            pin_level_nxt = 1'b1;
            state_cnt_nxt = cnt_inc;
            if (hbwd_pkg::cnt_ge(cnt_inc, pulse_r)) begin
              state_cnt_nxt = '0;
              wd_state_nxt  = hbwd_pkg::ST_HOLD;
              pin_level_nxt = 1'b0;
            end
          end
          hbwd_pkg::ST_HOLD: begin
            state_cnt_nxt = cnt_inc;
            if (hbwd_pkg::cnt_ge(cnt_inc, holdoff_r)) begin
              state_cnt_nxt = '0;
              wd_state_nxt  = hbwd_pkg::ST_WAIT;
            end
          end
          default: ;
        endcase
      end
      hbwd_pkg::KIND_HBEAT: begin
        last_int_nxt = since_hb_r;
        since_hb_nxt = '0;
      end
      hbwd_pkg::KIND_CAPTURE: begin
        cap_prev_nxt = cap_now_r;
        cap_now_nxt  = in_data.capture_value;
        fan_idle_nxt = '0;
      end
      default: begin
        // control write; an override forces the state, leaving pin and counter alone
        active_nxt = in_data.control_value[hbwd_pkg::CTL_ACTIVE_BIT];
        if (in_data.control_value[hbwd_pkg::CTL_OVERRIDE_BIT]) begin
          wd_state_nxt = in_data.control_value[1:0];
        end
      end
    endcase
  end

  // result fields from the updated state
  always_comb begin
    res_nxt.reboot_out         = pin_level_nxt;
    res_nxt.status             = {active_nxt, 5'b0, wd_state_nxt};
    res_nxt.reboot_count       = hbwd_pkg::cnt_out(state_cnt_nxt);
    res_nxt.fan_period         = hbwd_pkg::cnt_ge(fan_idle_nxt, fan_stale_r)
                                 ? hbwd_pkg::FAN_STALE_PERIOD
                                 : 16'(cap_now_nxt - cap_prev_nxt);
    res_nxt.heartbeat_interval = hbwd_pkg::cnt_out(last_int_nxt);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_state_r  <= hbwd_pkg::ST_INIT;
      active_r    <= 1'b1;
      pin_level_r <= 1'b0;
      state_cnt_r <= '0;
      since_hb_r  <= '0;
      last_int_r  <= '0;
      fan_idle_r  <= '0;
      cap_now_r   <= '0;
      cap_prev_r  <= '0;
    end else if (in_acc) begin
      wd_state_r  <= wd_state_nxt;
      active_r    <= active_nxt;
      pin_level_r <= pin_level_nxt;
      state_cnt_r <= state_cnt_nxt;
      since_hb_r  <= since_hb_nxt;
      last_int_r  <= last_int_nxt;
      fan_idle_r  <= fan_idle_nxt;
      cap_now_r   <= cap_now_nxt;
      cap_prev_r  <= cap_prev_nxt;
    end
  end

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // no request accepted while the skid stage is full
      if (out_take) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_vld_r || out_take) begin
        out_r     <= res_nxt;
        out_vld_r <= 1'b1;
      end else begin
        skid_r     <= res_nxt;
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

endmodule

/* test/heartbeat_reboot_watchdog_tb.sv */
// testbench for heartbeat_reboot_watchdog: a directed table of requests, then random
// phases under several limit settings, checked against an in-bench watchdog predictor
// depends on hbwd_pkg and the heartbeat_reboot_watchdog rtl

module heartbeat_reboot_watchdog_tb;

  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int RAND_PER_PHASE = 100;

  localparam hbwd_pkg::out_item_t NO_WANT = '0;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  hbwd_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  hbwd_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [15:0]         cfg_data;

  heartbeat_reboot_watchdog i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor copy of the limit registers
  logic [15:0] lim_init, lim_hb, lim_pulse, lim_hold, lim_stale;

  // predictor copy of the watchdog state
  logic [1:0]     wd_st;
  logic           wd_active;
  hbwd_pkg::cnt_t st_ctr;     // state counter, shown as reboot_count
  hbwd_pkg::cnt_t hb_age;     // ticks since the last heartbeat
  hbwd_pkg::cnt_t hb_last;    // age latched at the last heartbeat
  hbwd_pkg::cnt_t fan_age;    // ticks since the last tacho capture
  logic [15:0]    cap_new, cap_old;
  logic           rb_pin;

  hbwd_pkg::out_item_t owed[$];    // results predicted but not yet seen
  int                  mismatches;
  logic                quiet;      // set for stretches with no idling on either side

  // directed rows: request, whether the result is typed in, and that result
  typedef struct packed {
    hbwd_pkg::in_item_t  rq;
    logic                known;
    hbwd_pkg::out_item_t want;
  } step_t;

  // typed results: reboot_out, status, reboot_count, fan_period, heartbeat_interval
  step_t steps [24] = '{
    // first tick after reset, unused fields at all-ones
    {hbwd_pkg::KIND_TICK,    16'hFFFF, 8'hFF, 1'b1, 1'b0, 8'h80, 16'd1, 16'h0000, 16'd0},
    {hbwd_pkg::KIND_HBEAT,   16'h0000, 8'h00, 1'b1, 1'b0, 8'h80, 16'd1, 16'h0000, 16'd1},
    // capture extremes, the second one wraps the difference
    {hbwd_pkg::KIND_CAPTURE, 16'hFFFF, 8'h00, 1'b1, 1'b0, 8'h80, 16'd1, 16'hFFFF, 16'd1},
    {hbwd_pkg::KIND_CAPTURE, 16'h0000, 8'hFF, 1'b1, 1'b0, 8'h80, 16'd1, 16'h0001, 16'd1},
    // clear active, then a tick keeps the machine in initial wait
    {hbwd_pkg::KIND_CONTROL, 16'hFFFF, 8'h00, 1'b1, 1'b0, 8'h00, 16'd1, 16'h0001, 16'd1},
    {hbwd_pkg::KIND_TICK,    16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 16'd2, 16'h0001, 16'd1},
    // force reboot pulse with a counter already at the pulse limit
    {hbwd_pkg::KIND_CONTROL, 16'h0000, 8'h86, 1'b1, 1'b0, 8'h82, 16'd2, 16'h0001, 16'd1},
    {hbwd_pkg::KIND_TICK,    16'h0000, 8'h00, 1'b1, 1'b0, 8'h83, 16'd0, 16'h0001, 16'd1},
    // pulse again, leave it by override to initial: output stays high
    {hbwd_pkg::KIND_CONTROL, 16'h0000, 8'h86, 1'b1, 1'b0, 8'h82, 16'd0, 16'h0001, 16'd1},
    {hbwd_pkg::KIND_TICK,    16'h0000, 8'h00, 1'b1, 1'b1, 8'h82, 16'd1, 16'h0001, 16'd1},
    {hbwd_pkg::KIND_CONTROL, 16'h0000, 8'h84, 1'b1, 1'b1, 8'h80, 16'd1, 16'h0001, 16'd1},
    {hbwd_pkg::KIND_TICK,    16'h0000, 8'h00, 1'b1, 1'b1, 8'h80, 16'd2, 16'h0001, 16'd1},
    // no override bit: state kept; then override to wait
    {hbwd_pkg::KIND_CONTROL, 16'h0000, 8'h7B, 1'b1, 1'b1, 8'h00, 16'd2, 16'h0001, 16'd1},
    {hbwd_pkg::KIND_CONTROL, 16'h0000, 8'hFD, 1'b1, 1'b1, 8'h81, 16'd2, 16'h0001, 16'd1},
    // the rest goes through the predictor
    {hbwd_pkg::KIND_TICK,    16'h5555, 8'hAA, 1'b0, NO_WANT},
    {hbwd_pkg::KIND_HBEAT,   16'hAAAA, 8'h55, 1'b0, NO_WANT},
    {hbwd_pkg::KIND_CAPTURE, 16'h8000, 8'hFF, 1'b0, NO_WANT},
    // override to hold-off while inactive, the tick forces initial wait
    {hbwd_pkg::KIND_CONTROL, 16'h1234, 8'h07, 1'b0, NO_WANT},
    {hbwd_pkg::KIND_TICK,    16'h0000, 8'h00, 1'b0, NO_WANT},
    {hbwd_pkg::KIND_CONTROL, 16'h0000, 8'hFE, 1'b0, NO_WANT},
    {hbwd_pkg::KIND_TICK,    16'h0000, 8'h00, 1'b0, NO_WANT},
    {hbwd_pkg::KIND_TICK,    16'hFFFF, 8'hFF, 1'b0, NO_WANT},
    {hbwd_pkg::KIND_CONTROL, 16'h0000, 8'h83, 1'b0, NO_WANT},
    {hbwd_pkg::KIND_TICK,    16'h0000, 8'h00, 1'b0, NO_WANT}
  };

  function automatic hbwd_pkg::cnt_t bump(input hbwd_pkg::cnt_t v);
    return (v == '1) ? v : hbwd_pkg::cnt_t'(v + 1'b1);
  endfunction

  // counter against a 16-bit limit, both taken as unsigned
  function automatic logic reached(input hbwd_pkg::cnt_t c, input logic [15:0] lim);
    return 64'(c) >= 64'(lim);
  endfunction

  // applies one request to the predictor state and returns the expected result
  function automatic hbwd_pkg::out_item_t advance_watchdog(input hbwd_pkg::in_item_t rq);
    hbwd_pkg::out_item_t r;
    case (rq.kind)
      hbwd_pkg::KIND_TICK: begin
        hb_age = bump(hb_age);
        if (!reached(fan_age, lim_stale)) fan_age = bump(fan_age);
        // an inactive watchdog is pulled back to initial wait on every tick
        if (!wd_active) wd_st = hbwd_pkg::ST_INIT;
        case (wd_st)
          hbwd_pkg::ST_INIT: begin
            st_ctr = bump(st_ctr);
            if (reached(st_ctr, lim_init)) begin
              st_ctr = '0;
              wd_st = hbwd_pkg::ST_WAIT;
            end
          end
          hbwd_pkg::ST_WAIT: begin
            // counter untouched here
            if (reached(hb_age, lim_hb)) wd_st = hbwd_pkg::ST_PULSE;
          end
          hbwd_pkg::ST_PULSE: begin
            rb_pin = 1'b1;
            st_ctr = bump(st_ctr);
            if (reached(st_ctr, lim_pulse)) begin
              st_ctr = '0;
              wd_st = hbwd_pkg::ST_HOLD;
              rb_pin = 1'b0;
            end
          end
          default: begin
            st_ctr = bump(st_ctr);
            if (reached(st_ctr, lim_hold)) begin
              st_ctr = '0;
              wd_st = hbwd_pkg::ST_WAIT;
            end
          end
        endcase
      end
      hbwd_pkg::KIND_HBEAT: begin
        hb_last = hb_age;
        hb_age = '0;
      end
      hbwd_pkg::KIND_CAPTURE: begin
        cap_old = cap_new;
        cap_new = rq.capture_value;
        fan_age = '0;
      end
      default: begin
        // control write: active always follows, state only on override
        wd_active = rq.control_value[hbwd_pkg::CTL_ACTIVE_BIT];
        if (rq.control_value[hbwd_pkg::CTL_OVERRIDE_BIT]) wd_st = rq.control_value[1:0];
      end
    endcase
    r.reboot_out = rb_pin;
    r.status = {wd_active, 5'd0, wd_st};
    r.reboot_count = 16'(st_ctr);
    r.fan_period = reached(fan_age, lim_stale) ? hbwd_pkg::FAN_STALE_PERIOD
                                               : 16'(cap_new - cap_old);
    r.heartbeat_interval = 16'(hb_last);
    return r;
  endfunction

  // idle length for either side: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly ticks; control bytes are mostly well formed (active set, rare override)
  function automatic hbwd_pkg::in_item_t random_request();
    hbwd_pkg::in_item_t rq;
    int r;
    rq.capture_value = 16'($urandom);
    rq.control_value = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 58) rq.kind = hbwd_pkg::KIND_TICK;
    else if (r < 71) rq.kind = hbwd_pkg::KIND_HBEAT;
    else if (r < 85) rq.kind = hbwd_pkg::KIND_CAPTURE;
    else begin
      rq.kind = hbwd_pkg::KIND_CONTROL;
      if ($urandom_range(0, 9) != 0) begin
        rq.control_value[hbwd_pkg::CTL_ACTIVE_BIT] = ($urandom_range(0, 9) != 0);
        rq.control_value[hbwd_pkg::CTL_OVERRIDE_BIT] = ($urandom_range(0, 3) == 0);
      end
    end
    return rq;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(input hbwd_pkg::in_item_t rq, input logic known,
                      input hbwd_pkg::out_item_t want);
    hbwd_pkg::out_item_t p;
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (in_stall);
    // the request is taken at this edge, so the predictor moves now
    p = advance_watchdog(rq);
    owed.push_back(known ? want : p);
    @(negedge clk);
  endtask

  // drop valid for the requested idle gap, scrambling the idle payload
  task automatic idle_in(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      in_data <= $bits(hbwd_pkg::in_item_t)'($urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hbwd_pkg::REG_INITIAL_WAIT: lim_init = val;
      hbwd_pkg::REG_HB_LIMIT:     lim_hb = val;
      hbwd_pkg::REG_PULSE:        lim_pulse = val;
      hbwd_pkg::REG_HOLDOFF:      lim_hold = val;
      hbwd_pkg::REG_FAN_STALE:    lim_stale = val;
      default: ;        // spare indexes are ignored by the block
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_limits(input int lo, input int hi);
    write_reg(hbwd_pkg::REG_INITIAL_WAIT, 16'($urandom_range(lo, hi)));
    write_reg(hbwd_pkg::REG_HB_LIMIT, 16'($urandom_range(lo, hi)));
    write_reg(hbwd_pkg::REG_PULSE, 16'($urandom_range(lo, hi)));
    write_reg(hbwd_pkg::REG_HOLDOFF, 16'($urandom_range(lo, hi)));
    write_reg(hbwd_pkg::REG_FAN_STALE, 16'($urandom_range(lo, hi)));
  endtask

  // every request yields one result, so an empty queue means the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    while (owed.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      send(random_request(), 1'b0, NO_WANT);
      idle_in(gap_len());
    end
  endtask

  // result side: random stall bursts
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = gap_len();
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    hbwd_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed.size() == 0) begin
        note_mismatch("result with no request pending", 16'(out_data.status), 16'h0);
      end else begin
        want = owed.pop_front();
        if (out_data.reboot_out !== want.reboot_out)
          note_mismatch("reboot_out", 16'(out_data.reboot_out), 16'(want.reboot_out));
        if (out_data.status !== want.status)
          note_mismatch("status", 16'(out_data.status), 16'(want.status));
        if (out_data.reboot_count !== want.reboot_count)
          note_mismatch("reboot_count", out_data.reboot_count, want.reboot_count);
        if (out_data.fan_period !== want.fan_period)
          note_mismatch("fan_period", out_data.fan_period, want.fan_period);
        if (out_data.heartbeat_interval !== want.heartbeat_interval)
          note_mismatch("heartbeat_interval", out_data.heartbeat_interval,
                        want.heartbeat_interval);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    mismatches = 0;

    // predictor reset state
    lim_init = hbwd_pkg::RST_INITIAL_WAIT;
    lim_hb = hbwd_pkg::RST_HB_LIMIT;
    lim_pulse = hbwd_pkg::RST_PULSE;
    lim_hold = hbwd_pkg::RST_HOLDOFF;
    lim_stale = hbwd_pkg::RST_FAN_STALE;
    wd_st = hbwd_pkg::ST_INIT;
    wd_active = 1'b1;
    st_ctr = '0;
    hb_age = '0;
    hb_last = '0;
    fan_age = '0;
    cap_new = '0;
    cap_old = '0;
    rb_pin = 1'b0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table under the reset limits
    foreach (steps[i]) begin
      send(steps[i].rq, steps[i].known, steps[i].want);
      idle_in(gap_len());
    end
    run_phase(RAND_PER_PHASE);

    // smallest nonzero limits: every state turns over on its first tick
    settle();
    set_limits(1, 1);
    run_phase(RAND_PER_PHASE);

    // zero limits: transitions on the first tick, pulse rises and falls at once
    settle();
    set_limits(0, 0);
    run_phase(RAND_PER_PHASE);

    settle();
    set_limits(1, 8);
    run_phase(RAND_PER_PHASE);

    // small limits, then writes to the spare indexes that must change nothing
    settle();
    set_limits(0, 4);
    for (int i = hbwd_pkg::REG_FAN_STALE + 1; i < 2 ** $bits(cfg_index); i++)
      write_reg(3'(i), 16'($urandom));
    run_phase(RAND_PER_PHASE);

    // largest limits: no state counter reaches its limit and the fan never goes stale
    settle();
    set_limits(65535, 65535);
    run_phase(40);

    settle();
    set_limits(1, 12);
    run_phase(RAND_PER_PHASE);

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("FAILURE");
    $finish;
  end

endmodule
